// ===== hw/rtl/tinymt64_random_generator_assert.svh =====
// ----------------------------------------------------------------------------
// TinyMT64 generator assertion macros
// Shared property wrappers on the clk / arst_n pair of the asserting module.
// ----------------------------------------------------------------------------
`ifndef TINYMT64_RANDOM_GENERATOR_ASSERT_SVH
`define TINYMT64_RANDOM_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TMT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tinymt64 assertion failed");

// next-cycle implication, disabled in reset
`define TMT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tinymt64 assertion failed");

`endif

// ===== hw/rtl/tmt64_pkg.sv =====
// ----------------------------------------------------------------------------
// TinyMT64 generator package
// Widths, register map, reset values and sequencer states.
// ----------------------------------------------------------------------------
package tmt64_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned MAT_W   = 32;
	localparam int unsigned OUT_W   = 32;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned ROUND_W = 3;

	// register index, taken from paddr[4:3]
	typedef enum logic [1:0] {
		REG_MAT_ONE = 2'd0,
		REG_MAT_TWO = 2'd1,
		REG_TMAT    = 2'd2,
		REG_NONE    = 2'd3
	} reg_idx_t;

	localparam logic [MAT_W-1:0]  MAT_ONE_RST = 32'd4194639680;
	localparam logic [MAT_W-1:0]  MAT_TWO_RST = 32'd4291887092;
	localparam logic [WORD_W-1:0] TMAT_RST    = 64'd6399667842752446396;

	localparam logic [ROUND_W-1:0] ROUND_FIRST = 3'd1;
	localparam logic [ROUND_W-1:0] ROUND_LAST  = 3'd7;

	// fallback state when seeding lands on the all-zero orbit ('T', 'M')
	localparam logic [WORD_W-1:0] CERT_WORD0 = 64'd84;
	localparam logic [WORD_W-1:0] CERT_WORD1 = 64'd77;

	localparam logic OP_SEED = 1'b0;
	localparam logic OP_NEXT = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROUND = 5'b00010,
		ST_CERT  = 5'b00100,
		ST_ADV   = 5'b01000,
		ST_TEMP  = 5'b10000
	} state_t;

endpackage

// ===== hw/rtl/tinymt64_random_generator.sv =====
// ----------------------------------------------------------------------------
// TinyMT64 random generator
// Seeds and advances a 127-bit TinyMT64 state and delivers tempered words.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): opcode seed loads seed_value and runs
// the seven mixing rounds plus period certification; it gives no result.
// Opcode next advances the state and delivers one random_word beat on the
// output channel (out_valid / out_stall).
// All additions go through a single shared 64-bit adder under a small
// sequencer; the multiply by 2^63-1 reduces to a subtract and a top-bit flip.
// A next item holds the input stalled through the advance and temper steps,
// and its word is registered as the temper step completes; the block takes
// no new item until the last one is through. A seed item loads, runs 7
// rounds and certifies; the adder does one round per cycle.
// A finished word waits in the output register while the receiver stalls;
// the block still takes the next item, and holds in the temper step only if
// a second word is ready before the first is taken.
// Reset clears both state words to zero and restores the default mat1, mat2
// and tmat registers; next items before any seed then return zero.
// Config: APB mat1, mat2 (32-bit), tmat (64-bit) at byte address 0, 8, 16.
module tinymt64_random_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [tmt64_pkg::WORD_W-1:0]  seed_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tmt64_pkg::OUT_W-1:0]   random_word,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tmt64_pkg::ADDR_W-1:0]  paddr,
	input  logic [tmt64_pkg::WORD_W-1:0]  pwdata,
	output logic [tmt64_pkg::WORD_W-1:0]  prdata,
	output logic                          pready
);

	localparam int unsigned W  = tmt64_pkg::WORD_W;
	localparam int unsigned MW = tmt64_pkg::MAT_W;

	tmt64_pkg::state_t            state_q;
	logic [tmt64_pkg::ROUND_W-1:0] round_q;
	logic [W-1:0]                 w0_q, w1_q;
	logic [MW-1:0]                mat_one_q, mat_two_q;
	logic [W-1:0]                 tmat_q;
	logic                         out_valid_q;
	logic [tmt64_pkg::OUT_W-1:0]  random_word_q;

	tmt64_pkg::reg_idx_t          reg_idx;
	logic                         cfg_wr;
	logic                         in_acc;
	logic                         out_free;

	logic [W-1:0]                 add_a, add_b, add_sum;
	logic                         add_cin;

	logic [W-1:0]                 rnd_p, rnd_t, rnd_mix;
	logic [W-1:0]                 adv_x0, adv_x1, adv_x2, adv_x3, adv_x4;
	logic [W-1:0]                 tmp_x, tmp_out;

	assign pready   = 1'b1;
	assign reg_idx  = tmt64_pkg::reg_idx_t'(paddr[4:3]);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_stall = (state_q != tmt64_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign random_word = random_word_q;

	always_comb begin
		unique case (reg_idx)
			tmt64_pkg::REG_MAT_ONE: prdata = {{(W-MW){1'b0}}, mat_one_q};
			tmt64_pkg::REG_MAT_TWO: prdata = {{(W-MW){1'b0}}, mat_two_q};
			tmt64_pkg::REG_TMAT:    prdata = tmat_q;
			default:                prdata = '0;
		endcase
	end

	// seeding round: p is the word written by the previous round
	assign rnd_p   = round_q[0] ? w0_q : w1_q;
	assign rnd_t   = rnd_p ^ (rnd_p >> 62);
	// r + t*(2^63-1) == (r - t) with bit 63 flipped by t[0]
	assign rnd_mix = add_sum ^ {rnd_t[0], {(W-1){1'b0}}};

	// shared adder
	always_comb begin
		add_a   = w0_q;
		add_b   = w1_q;
		add_cin = 1'b0;
		if (state_q == tmt64_pkg::ST_ROUND) begin
			add_a   = {{(W-tmt64_pkg::ROUND_W){1'b0}}, round_q};
			add_b   = ~rnd_t;
			add_cin = 1'b1;
		end
	end
	assign add_sum = add_a + add_b + {{(W-1){1'b0}}, add_cin};

	// xor-shift recurrence
	assign adv_x0 = {1'b0, w0_q[W-2:0]} ^ w1_q;
	assign adv_x1 = adv_x0 ^ (adv_x0 << 12);
	assign adv_x2 = adv_x1 ^ (adv_x1 >> 32);
	assign adv_x3 = adv_x2 ^ (adv_x2 << 32);
	assign adv_x4 = adv_x3 ^ (adv_x3 << 11);

	// tempering
	assign tmp_x   = add_sum ^ (w0_q >> 8);
	assign tmp_out = tmp_x[0] ? (tmp_x ^ tmat_q) : tmp_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_one_q <= tmt64_pkg::MAT_ONE_RST;
			mat_two_q <= tmt64_pkg::MAT_TWO_RST;
			tmat_q    <= tmt64_pkg::TMAT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				tmt64_pkg::REG_MAT_ONE: mat_one_q <= pwdata[MW-1:0];
				tmt64_pkg::REG_MAT_TWO: mat_two_q <= pwdata[MW-1:0];
				tmt64_pkg::REG_TMAT:    tmat_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmt64_pkg::ST_IDLE;
			round_q     <= tmt64_pkg::ROUND_FIRST;
			w0_q        <= '0;
			w1_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new beat, else drop the one just taken
			if (state_q == tmt64_pkg::ST_TEMP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				tmt64_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (opcode == tmt64_pkg::OP_SEED) begin
							w0_q    <= seed_value ^ {mat_one_q, {(W-MW){1'b0}}};
							w1_q    <= {{(W-MW){1'b0}}, mat_two_q} ^ tmat_q;
							round_q <= tmt64_pkg::ROUND_FIRST;
							state_q <= tmt64_pkg::ST_ROUND;
						end else begin
							state_q <= tmt64_pkg::ST_ADV;
						end
					end
				end
				tmt64_pkg::ST_ROUND: begin
					if (round_q[0]) begin
						w1_q <= w1_q ^ rnd_mix;
					end else begin
						w0_q <= w0_q ^ rnd_mix;
					end
					round_q <= round_q + 1'b1;
					if (round_q == tmt64_pkg::ROUND_LAST) begin
						state_q <= tmt64_pkg::ST_CERT;
					end
				end
				tmt64_pkg::ST_CERT: begin
					if (w0_q[W-2:0] == '0 && w1_q == '0) begin
						w0_q <= tmt64_pkg::CERT_WORD0;
						w1_q <= tmt64_pkg::CERT_WORD1;
					end
					state_q <= tmt64_pkg::ST_IDLE;
				end
				tmt64_pkg::ST_ADV: begin
					w0_q    <= w1_q ^ (adv_x4[0] ? {{(W-MW){1'b0}}, mat_one_q} : '0);
					w1_q    <= adv_x4 ^ (adv_x4[0] ? {mat_two_q, {(W-MW){1'b0}}} : '0);
					state_q <= tmt64_pkg::ST_TEMP;
				end
				tmt64_pkg::ST_TEMP: begin
					// hold until the output register frees up
					if (out_free) begin
						state_q <= tmt64_pkg::ST_IDLE;
					end
				end
				default: state_q <= tmt64_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tmt64_pkg::ST_TEMP && out_free) begin
			random_word_q <= tmp_out[tmt64_pkg::OUT_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/tmt64_checker.sv =====
// ----------------------------------------------------------------------------
// TinyMT64 generator port checker
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`include "tinymt64_random_generator_assert.svh"

module tmt64_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [tmt64_pkg::OUT_W-1:0]  random_word
);

	// busy right after taking an item
	`TMT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// a new beat only appears after a busy cycle
	`TMT_ASSERT_NOW(a_beat_after_work, $rose(out_valid), $past(in_stall))
	// stalled beat stays valid and unchanged
	`TMT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`TMT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(random_word))

endmodule

bind tinymt64_random_generator tmt64_checker u_tmt64_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.random_word (random_word)
);
